// ===== rtl/core/deq_pkg.sv =====
// Package for the double-ended queue: item types, command and status codes,
// controller state and control signal group. Used by double_ended_queue, deq_ctrl and deq_dp.
package deq_pkg;

   localparam int DEQ_CAPACITY = 16;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_BACK  = 3'd5,
      CMD_CLEAR      = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [4:0]         occupancy;
   } rsp_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_EXEC = 2'd1,
      FSM_RESP = 2'd2
   } fsm_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic respond;
   } ctrl_type;

endpackage

// ===== rtl/core/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words over a circular RAM store.
// The result strobe rises in the respond state, which follows the capture and execute
// states; a new item is taken only once the controller is idle again after stepping
// capture, execute (RAM access and pointer update) and respond. Results cannot be stalled.
// Synchronous reset empties the queue; store contents stay undefined until written.
// Depends on deq_pkg, deq_ctrl, deq_dp, deq_ram.
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int CAPACITY = DEQ_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctrl_type ctrl;

   deq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   deq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/deq_ctrl.sv =====
// Controller state machine for the double-ended queue: sequences capture,
// execute and respond. Depends on deq_pkg.
module deq_ctrl
   import deq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   output ctrl_type ctrl
);

   fsm_type state_ff;
   fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      busy     = 1'b1;
      case (state_ff)
         FSM_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctrl.capture = 1'b1;
               state_in     = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            ctrl.execute = 1'b1;
            state_in     = FSM_RESP;
         end
         FSM_RESP: begin
            ctrl.respond = 1'b1;
            state_in     = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/deq_dp.sv =====
// Datapath for the double-ended queue: pointers, count, word store and
// response registers. Depends on deq_pkg and deq_ram.
module deq_dp
   import deq_pkg::*;
#(
   parameter int CAPACITY = DEQ_CAPACITY
) (
   input  logic     clock,
   input  logic     reset,
   input  ctrl_type ctrl,
   input  req_type  req_data,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   logic [2:0]         cmd_ff;
   logic signed [31:0] value_ff;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [1:0]         status_ff, status_in;
   logic               hit_ff, hit_in;
   logic               valid_ff;

   logic [PTR_W-1:0]   head_inc, head_dec, tail_inc, tail_dec;
   logic               is_full, is_empty;
   logic               wr_en, rd_en;
   logic [PTR_W-1:0]   wr_addr, rd_addr;
   logic [31:0]        rd_data;

   assign head_inc = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? PTR_LAST : head_ff - 1'b1;
   assign tail_inc = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? PTR_LAST : tail_ff - 1'b1;
   assign is_full  = (count_ff == CNT_FULL);
   assign is_empty = (count_ff == '0);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      hit_in    = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = tail_ff;
      rd_addr   = head_ff;
      case (cmd_ff)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (cmd_ff == CMD_PUSH_FRONT) begin
                  wr_addr = head_dec;
                  head_in = head_dec;
               end else begin
                  tail_in = tail_inc;
               end
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               rd_en  = 1'b1;
               hit_in = 1'b1;
               if (cmd_ff == CMD_POP_BACK || cmd_ff == CMD_PEEK_BACK) begin
                  rd_addr = tail_dec;
               end
               if (cmd_ff == CMD_POP_FRONT) begin
                  head_in  = head_inc;
                  count_in = count_ff - 1'b1;
               end
               if (cmd_ff == CMD_POP_BACK) begin
                  tail_in  = tail_dec;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         CMD_CLEAR: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff   <= req_data.command;
         value_ff <= req_data.push_value;
      end
      if (ctrl.execute) begin
         status_ff <= status_in;
         hit_ff    <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.execute;
         if (ctrl.execute) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   deq_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en && ctrl.execute),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (rd_en && ctrl.execute),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid           = valid_ff && ctrl.respond;
   assign rsp_data.read_value = hit_ff ? rd_data : '0;
   assign rsp_data.status     = status_ff;
   assign rsp_data.occupancy  = 5'(count_ff);

endmodule
